>>> hdl/ray_box_intersection_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ray/box intersection block
// ---------------------------------------------------------------------------
`ifndef RAY_BOX_INTERSECTION_ASSERT_SVH
`define RAY_BOX_INTERSECTION_ASSERT_SVH

// same-cycle implication, off during reset
`define RBI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbi: implication check failed");

// next-cycle implication, off during reset
`define RBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbi: next-cycle check failed");

// next-cycle implication that also holds across reset
`define RBI_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rbi: reset check failed");

`endif

>>> hdl/rbi_pkg.sv
// ---------------------------------------------------------------------------
// rbi_pkg
// Shared constants and width helpers for the ray/box intersection block.
// ---------------------------------------------------------------------------
package rbi_pkg;

    parameter int unsigned RBI_COORD_WIDTH = 32;
    parameter int unsigned RBI_FRAC_BITS   = 16;

    // round a bit count up to whole bytes
    function automatic int rbi_bytes(input int bits);
        return ((bits + 7) >> 3) << 3;
    endfunction

    // nine signed coordinates plus three half-extents one bit narrower
    function automatic int rbi_in_width(input int w);
        return rbi_bytes(12 * w - 3);
    endfunction

    function automatic int rbi_out_width(input int w);
        return rbi_bytes(4 * w);
    endfunction

    // pos, dir, lo, hi, plane per axis, inside flag, active and sign per axis
    function automatic int rbi_sb_width(input int w);
        return 15 * w + 7;
    endfunction

endpackage

>>> hdl/rbi_front.sv
// ---------------------------------------------------------------------------
// rbi_front
// Box bounds, slab classification and divider operand setup (3 stages).
// ---------------------------------------------------------------------------
module rbi_front import rbi_pkg::*; #(
    parameter int unsigned W    = RBI_COORD_WIDTH,
    parameter int unsigned SB_W = rbi_sb_width(RBI_COORD_WIDTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [rbi_in_width(W)-1:0]   i_tdata,
    output logic                         o_valid,
    output logic [2:0][W-1:0]            o_num,
    output logic [2:0][W-1:0]            o_den,
    output logic [SB_W-1:0]              o_sb
);

    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

    typedef struct packed {
        logic [2:0][W-1:0] pos;
        logic [2:0][W-1:0] dir;
        logic [2:0][W-1:0] lo;
        logic [2:0][W-1:0] hi;
        logic [2:0][W-1:0] plane;
        logic              in_box;
        logic [2:0]        act;
        logic [2:0]        neg;
    } t_sb;

    function automatic logic [W-1:0] sat(input logic [W:0] x);
        if (x[W] != x[W-1]) begin
            return x[W] ? MINV : MAXV;
        end
        return x[W-1:0];
    endfunction

    // stage A: bounds
    logic              r_a_vld;
    logic [2:0][W-1:0] r_a_pos, r_a_dir, r_a_lo, r_a_hi;
    logic [2:0][W-1:0] n_a_pos, n_a_dir, n_a_lo, n_a_hi;

    always_comb begin
        logic [W-1:0] c;
        logic [W:0]   h;
        for (int i = 0; i < 3; i++) begin
            c          = i_tdata[W*(6+i) +: W];
            h          = {2'b00, i_tdata[9*W + i*(W-1) +: W-1]};
            n_a_pos[i] = i_tdata[W*i +: W];
            n_a_dir[i] = i_tdata[W*(3+i) +: W];
            n_a_lo[i]  = sat({c[W-1], c} - h);
            n_a_hi[i]  = sat({c[W-1], c} + h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
        end
        if (i_en) begin
            r_a_pos <= n_a_pos;
            r_a_dir <= n_a_dir;
            r_a_lo  <= n_a_lo;
            r_a_hi  <= n_a_hi;
        end
    end

    // stage B: classify each axis against its slab
    logic              r_b_vld, r_b_inside;
    logic [2:0]        r_b_act, n_b_act;
    logic [2:0][W-1:0] r_b_pos, r_b_dir, r_b_lo, r_b_hi, r_b_plane, n_b_plane;
    logic              n_b_inside;

    always_comb begin
        logic below, above;
        n_b_inside = 1'b1;
        for (int i = 0; i < 3; i++) begin
            below        = $signed(r_a_pos[i]) < $signed(r_a_lo[i]);
            above        = $signed(r_a_pos[i]) > $signed(r_a_hi[i]);
            n_b_plane[i] = below ? r_a_lo[i] : (above ? r_a_hi[i] : '0);
            n_b_act[i]   = (below || above) && (r_a_dir[i] != '0);
            if (below || above) begin
                n_b_inside = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
        if (i_en) begin
            r_b_pos    <= r_a_pos;
            r_b_dir    <= r_a_dir;
            r_b_lo     <= r_a_lo;
            r_b_hi     <= r_a_hi;
            r_b_plane  <= n_b_plane;
            r_b_act    <= n_b_act;
            r_b_inside <= n_b_inside;
        end
    end

    // stage C: saturated plane offset, magnitudes and quotient sign
    logic              r_c_vld;
    logic [2:0][W-1:0] r_c_num, r_c_den, n_c_num, n_c_den;
    t_sb               r_c_sb, n_c_sb;

    always_comb begin
        logic [W-1:0] diff;
        n_c_sb        = '0;
        n_c_sb.pos    = r_b_pos;
        n_c_sb.dir    = r_b_dir;
        n_c_sb.lo     = r_b_lo;
        n_c_sb.hi     = r_b_hi;
        n_c_sb.plane  = r_b_plane;
        n_c_sb.in_box = r_b_inside;
        n_c_sb.act    = r_b_act;
        for (int i = 0; i < 3; i++) begin
            diff          = sat({r_b_plane[i][W-1], r_b_plane[i]} -
                                {r_b_pos[i][W-1], r_b_pos[i]});
            n_c_sb.neg[i] = diff[W-1] ^ r_b_dir[i][W-1];
            n_c_num[i]    = diff[W-1] ? (~diff + 1'b1) : diff;
            n_c_den[i]    = r_b_dir[i][W-1] ? (~r_b_dir[i] + 1'b1) : r_b_dir[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= r_b_vld;
        end
        if (i_en) begin
            r_c_num <= n_c_num;
            r_c_den <= n_c_den;
            r_c_sb  <= n_c_sb;
        end
    end

    assign o_valid = r_c_vld;
    assign o_num   = r_c_num;
    assign o_den   = r_c_den;
    assign o_sb    = r_c_sb;

endmodule

>>> hdl/rbi_div.sv
// ---------------------------------------------------------------------------
// rbi_div
// Three-lane pipelined restoring divider, one quotient bit per stage,
// computing (num << F) / den with the item's sideband riding alongside.
// ---------------------------------------------------------------------------
module rbi_div import rbi_pkg::*; #(
    parameter int unsigned W    = RBI_COORD_WIDTH,
    parameter int unsigned F    = RBI_FRAC_BITS,
    parameter int unsigned SB_W = rbi_sb_width(RBI_COORD_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2:0][W-1:0]     i_num,
    input  logic [2:0][W-1:0]     i_den,
    input  logic [SB_W-1:0]       i_sb,
    output logic                  o_valid,
    output logic [2:0][W+F-1:0]   o_quo,
    output logic [SB_W-1:0]       o_sb
);

    localparam int unsigned DW = W + F;

    logic [2:0][W:0]    r_rem [DW];
    logic [2:0][DW-1:0] r_num [DW];
    logic [2:0][DW-1:0] r_quo [DW];
    logic [2:0][W-1:0]  r_den [DW];
    logic [SB_W-1:0]    r_sb  [DW];
    logic [DW-1:0]      r_vld;

    logic [2:0][W:0]    p_rem [DW];
    logic [2:0][DW-1:0] p_num [DW];
    logic [2:0][DW-1:0] p_quo [DW];
    logic [2:0][W-1:0]  p_den [DW];
    logic [SB_W-1:0]    p_sb  [DW];
    logic [DW-1:0]      p_vld;

    logic [2:0][W:0]    n_rem [DW];
    logic [2:0][DW-1:0] n_num [DW];
    logic [2:0][DW-1:0] n_quo [DW];

    // stage inputs: the item from upstream, then the previous stage
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            p_rem[0][j] = '0;
            p_num[0][j] = {i_num[j], {F{1'b0}}};
            p_quo[0][j] = '0;
        end
        p_den[0] = i_den;
        p_sb[0]  = i_sb;
        p_vld[0] = i_valid;
        for (int k = 1; k < DW; k++) begin
            p_rem[k] = r_rem[k-1];
            p_num[k] = r_num[k-1];
            p_quo[k] = r_quo[k-1];
            p_den[k] = r_den[k-1];
            p_sb[k]  = r_sb[k-1];
            p_vld[k] = r_vld[k-1];
        end
    end

    always_comb begin
        logic [W:0] sh;
        logic       ge;
        for (int k = 0; k < DW; k++) begin
            for (int j = 0; j < 3; j++) begin
                sh             = {p_rem[k][j][W-1:0], p_num[k][j][DW-1]};
                ge             = sh >= {1'b0, p_den[k][j]};
                n_rem[k][j]    = ge ? (sh - {1'b0, p_den[k][j]}) : sh;
                n_quo[k][j]    = {p_quo[k][j][DW-2:0], ge};
                n_num[k][j]    = {p_num[k][j][DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= p_vld;
        end
        if (i_en) begin
            r_rem <= n_rem;
            r_num <= n_num;
            r_quo <= n_quo;
            r_den <= p_den;
            r_sb  <= p_sb;
        end
    end

    assign o_valid = r_vld[DW-1];
    assign o_quo   = r_quo[DW-1];
    assign o_sb    = r_sb[DW-1];

endmodule

>>> hdl/rbi_back.sv
// ---------------------------------------------------------------------------
// rbi_back
// Distance saturation, largest-distance pick, hit point and box check
// (7 stages, the last one is the output register).
// ---------------------------------------------------------------------------
module rbi_back import rbi_pkg::*; #(
    parameter int unsigned W    = RBI_COORD_WIDTH,
    parameter int unsigned F    = RBI_FRAC_BITS,
    parameter int unsigned SB_W = rbi_sb_width(RBI_COORD_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2:0][W+F-1:0]   i_quo,
    input  logic [SB_W-1:0]       i_sb,
    output logic                  o_valid,
    output logic                  o_hit,
    output logic [2:0][W-1:0]     o_pt,
    output logic [W-1:0]          o_dist
);

    localparam logic [W-1:0] MINV    = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAXV    = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_ONE = (F >= W - 1) ? MINV :
                                       W'((~(W'(1) << F)) + W'(1));

    typedef struct packed {
        logic [2:0][W-1:0] pos;
        logic [2:0][W-1:0] dir;
        logic [2:0][W-1:0] lo;
        logic [2:0][W-1:0] hi;
        logic [2:0][W-1:0] plane;
        logic              in_box;
        logic [2:0]        act;
        logic [2:0]        neg;
    } t_sb;

    function automatic logic [W-1:0] sat(input logic [W:0] x);
        if (x[W] != x[W-1]) begin
            return x[W] ? MINV : MAXV;
        end
        return x[W-1:0];
    endfunction

    t_sb sb_in;
    assign sb_in = i_sb;

    // stage 1: saturated candidate distances
    logic              r1_vld;
    logic [2:0][W-1:0] r1_t, n1_t;
    t_sb               r1_sb;

    always_comb begin
        logic big;
        for (int i = 0; i < 3; i++) begin
            big = |i_quo[i][W+F-1:W-1];
            if (!sb_in.act[i]) begin
                n1_t[i] = NEG_ONE;
            end else if (big) begin
                n1_t[i] = sb_in.neg[i] ? MINV : MAXV;
            end else begin
                n1_t[i] = sb_in.neg[i] ? (~i_quo[i][W-1:0] + 1'b1) : i_quo[i][W-1:0];
            end
        end
    end

    // stage 2: largest distance, lowest axis on ties
    logic         r2_vld;
    logic [W-1:0] r2_dist, n2_dist, tmp01;
    logic [2:0]   r2_w, n2_w;
    t_sb          r2_sb;

    always_comb begin
        logic sel1, sel2;
        sel1    = $signed(r1_t[0]) < $signed(r1_t[1]);
        tmp01   = sel1 ? r1_t[1] : r1_t[0];
        sel2    = $signed(tmp01) < $signed(r1_t[2]);
        n2_dist = sel2 ? r1_t[2] : tmp01;
        n2_w    = sel2 ? 3'b100 : (sel1 ? 3'b010 : 3'b001);
    end

    // stage 3: magnitudes for the multiplier
    logic              r3_vld;
    logic [W-1:0]      r3_mdist, r3_dist;
    logic [2:0][W-1:0] r3_mdir, n3_mdir;
    logic [2:0]        r3_sgn, n3_sgn;
    logic [2:0]        r3_w;
    t_sb               r3_sb;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_mdir[i] = r2_sb.dir[i][W-1] ? (~r2_sb.dir[i] + 1'b1) : r2_sb.dir[i];
            n3_sgn[i]  = r2_dist[W-1] ^ r2_sb.dir[i][W-1];
        end
    end

    // stage 4: exact products
    logic                r4_vld;
    logic [2:0][2*W-1:0] r4_prod, n4_prod;
    logic [2:0]          r4_sgn, r4_w;
    logic [W-1:0]        r4_dist;
    t_sb                 r4_sb;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_prod[i] = {{W{1'b0}}, r3_mdist} * {{W{1'b0}}, r3_mdir[i]};
        end
    end

    // stage 5: drop fraction bits, saturate
    logic              r5_vld;
    logic [2:0][W-1:0] r5_fm, n5_fm;
    logic [2:0]        r5_w;
    logic [W-1:0]      r5_dist;
    t_sb               r5_sb;

    always_comb begin
        logic [W-1:0] s;
        logic         big;
        for (int i = 0; i < 3; i++) begin
            s   = r4_prod[i][F +: W];
            big = |r4_prod[i][2*W-1:F+W-1];
            if (big) begin
                n5_fm[i] = r4_sgn[i] ? MINV : MAXV;
            end else begin
                n5_fm[i] = r4_sgn[i] ? (~s + 1'b1) : s;
            end
        end
    end

    // stage 6: add the origin
    logic              r6_vld;
    logic [2:0][W-1:0] r6_pt, n6_pt;
    logic [2:0]        r6_w;
    logic [W-1:0]      r6_dist;
    t_sb               r6_sb;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n6_pt[i] = sat({r5_sb.pos[i][W-1], r5_sb.pos[i]} + {r5_fm[i][W-1], r5_fm[i]});
        end
    end

    // stage 7: box check and result selection
    logic              r7_vld, r7_hit, n7_hit;
    logic [2:0][W-1:0] r7_pt, n7_pt;
    logic [W-1:0]      r7_dist, n7_dist;

    always_comb begin
        logic miss;
        miss = r6_dist[W-1];
        for (int i = 0; i < 3; i++) begin
            if (!r6_w[i] && ($signed(r6_pt[i]) < $signed(r6_sb.lo[i]) ||
                             $signed(r6_pt[i]) > $signed(r6_sb.hi[i]))) begin
                miss = 1'b1;
            end
        end
        n7_hit  = r6_sb.in_box || !miss;
        n7_dist = r6_sb.in_box ? '0 : r6_dist;
        for (int i = 0; i < 3; i++) begin
            if (r6_sb.in_box) begin
                n7_pt[i] = r6_sb.pos[i];
            end else if (!miss) begin
                n7_pt[i] = r6_w[i] ? r6_sb.plane[i] : r6_pt[i];
            end else begin
                n7_pt[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
        if (i_en) begin
            r1_t     <= n1_t;
            r1_sb    <= sb_in;
            r2_dist  <= n2_dist;
            r2_w     <= n2_w;
            r2_sb    <= r1_sb;
            r3_mdist <= r2_dist[W-1] ? (~r2_dist + 1'b1) : r2_dist;
            r3_dist  <= r2_dist;
            r3_mdir  <= n3_mdir;
            r3_sgn   <= n3_sgn;
            r3_w     <= r2_w;
            r3_sb    <= r2_sb;
            r4_prod  <= n4_prod;
            r4_sgn   <= r3_sgn;
            r4_w     <= r3_w;
            r4_dist  <= r3_dist;
            r4_sb    <= r3_sb;
            r5_fm    <= n5_fm;
            r5_w     <= r4_w;
            r5_dist  <= r4_dist;
            r5_sb    <= r4_sb;
            r6_pt    <= n6_pt;
            r6_w     <= r5_w;
            r6_dist  <= r5_dist;
            r6_sb    <= r5_sb;
            r7_hit   <= n7_hit;
            r7_pt    <= n7_pt;
            r7_dist  <= n7_dist;
        end
    end

    assign o_valid = r7_vld;
    assign o_hit   = r7_hit;
    assign o_pt    = r7_pt;
    assign o_dist  = r7_dist;

endmodule

>>> hdl/ray_box_intersection.sv
// ---------------------------------------------------------------------------
// ray_box_intersection
// Fixed-point ray versus axis-aligned box test, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream takes one ray plus box per item: origin, direction, box
//   center (signed Q format) and half-extents. Master stream returns one
//   item per input: hit flag in tuser, hit point and distance in tdata.
//   Throughput: one item per cycle, sustained while the master side accepts.
//   The divider resolves one quotient bit per stage, for all three axes
//   in parallel.
//   Stall: when the master side holds tready low with a result waiting,
//   the whole pipeline freezes and s_axis_tready drops; nothing is lost
//   or repeated. Bubbles in the pipe do not block accepting new items
//   while the output register is empty or being drained.
//   Reset: synchronous, active low; clears all valid bits, so the block
//   comes out empty and ready.
// ---------------------------------------------------------------------------
module ray_box_intersection import rbi_pkg::*; #(
    parameter int unsigned COORD_WIDTH = RBI_COORD_WIDTH,
    parameter int unsigned FRAC_BITS   = RBI_FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // center_x, center_y, center_z, half_x, half_y, half_z, zero fill
    input  logic [rbi_in_width(COORD_WIDTH)-1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // point_x, point_y, point_z, distance
    output logic [rbi_out_width(COORD_WIDTH)-1:0] m_axis_tdata,
    // hit_flag
    output logic                                 m_axis_tuser
);

    localparam int unsigned W     = COORD_WIDTH;
    localparam int unsigned F     = FRAC_BITS;
    localparam int unsigned SB_W  = rbi_sb_width(COORD_WIDTH);
    localparam int unsigned OUT_W = rbi_out_width(COORD_WIDTH);

    logic                  advance;
    logic                  fr_valid, dv_valid;
    logic [2:0][W-1:0]     fr_num, fr_den;
    logic [SB_W-1:0]       fr_sb, dv_sb;
    logic [2:0][W+F-1:0]   dv_quo;
    logic                  bk_hit;
    logic [2:0][W-1:0]     bk_pt;
    logic [W-1:0]          bk_dist;

    // whole pipe moves unless a result sits unaccepted at the output
    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    rbi_front #(.W(W), .SB_W(SB_W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_valid (s_axis_tvalid),
        .i_tdata (s_axis_tdata),
        .o_valid (fr_valid),
        .o_num   (fr_num),
        .o_den   (fr_den),
        .o_sb    (fr_sb)
    );

    rbi_div #(.W(W), .F(F), .SB_W(SB_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_valid (fr_valid),
        .i_num   (fr_num),
        .i_den   (fr_den),
        .i_sb    (fr_sb),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_sb    (dv_sb)
    );

    rbi_back #(.W(W), .F(F), .SB_W(SB_W)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_valid (dv_valid),
        .i_quo   (dv_quo),
        .i_sb    (dv_sb),
        .o_valid (m_axis_tvalid),
        .o_hit   (bk_hit),
        .o_pt    (bk_pt),
        .o_dist  (bk_dist)
    );

    assign m_axis_tdata = OUT_W'({bk_dist, bk_pt[2], bk_pt[1], bk_pt[0]});
    assign m_axis_tuser = bk_hit;

endmodule

>>> hdl/rbi_checker.sv
// ---------------------------------------------------------------------------
// rbi_checker
// Port-level checks for the ray/box intersection block, bound to the top.
// ---------------------------------------------------------------------------
`include "ray_box_intersection_assert.svh"

module rbi_checker import rbi_pkg::*; #(
    parameter int unsigned COORD_WIDTH = RBI_COORD_WIDTH
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  s_axis_tvalid,
    input logic                                  s_axis_tready,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [rbi_out_width(COORD_WIDTH)-1:0]  m_axis_tdata,
    input logic                                  m_axis_tuser
);

    localparam int unsigned W = COORD_WIDTH;

    logic                                   out_stall, out_hit, out_miss, in_blocked;
    logic [rbi_out_width(COORD_WIDTH):0]    out_data;

    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign out_hit    = m_axis_tvalid && m_axis_tuser;
    assign out_miss   = m_axis_tvalid && !m_axis_tuser;
    assign in_blocked = s_axis_tvalid && !s_axis_tready;
    assign out_data   = {m_axis_tuser, m_axis_tdata};

    `RBI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(out_data))
    `RBI_ASSERT_IMPL(a_miss_zero_point, i_clk, i_rst_n, out_miss, m_axis_tdata[3*W-1:0] == '0)
    `RBI_ASSERT_IMPL(a_hit_dist_nonneg, i_clk, i_rst_n, out_hit, !m_axis_tdata[4*W-1])
    `RBI_ASSERT_IMPL(a_stall_only, i_clk, i_rst_n, in_blocked, out_stall)
    `RBI_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind ray_box_intersection rbi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbi_checker (.*);
